// ===== sv/media_frame_header_parser_top_defines.svh =====
// ----------------------------------------------------------------------------
// Media frame header parser assertion macros
// Shared property shapes for the checks inside the parser modules.
// ----------------------------------------------------------------------------
`ifndef MEDIA_FRAME_HEADER_PARSER_TOP_DEFINES_SVH
`define MEDIA_FRAME_HEADER_PARSER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFHP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MFHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/mfhp_pkg.sv =====
// ----------------------------------------------------------------------------
// Media frame header parser package
// Types, register indexes, codes and layout constants shared by the parser.
// ----------------------------------------------------------------------------
package mfhp_pkg;

   localparam int POSITION_BITS_DEF = 16;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAGIC      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ID_LEN = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_KIND   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONF_MASK  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_MASK   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACK_MASK   = 3'd5;

   localparam logic [7:0] RST_MAGIC      = 8'd0;
   localparam logic [7:0] RST_MAX_ID_LEN = 8'd15;
   localparam logic [3:0] RST_MAX_KIND   = 4'd3;
   localparam logic [7:0] RST_CONF_MASK  = 8'd16;
   localparam logic [7:0] RST_END_MASK   = 8'd32;
   localparam logic [7:0] RST_ACK_MASK   = 8'd64;

   // Frame layout. Offsets fit in ten bits for any legal id lengths.
   localparam int KIND_BITS = 4;
   localparam int OFS_BITS  = 10;
   localparam logic [OFS_BITS-1:0] POS_KIND      = 10'd1;
   localparam logic [OFS_BITS-1:0] POS_TIME      = 10'd6;
   localparam logic [OFS_BITS-1:0] POS_SRC_LEN   = 10'd10;
   localparam logic [OFS_BITS-1:0] POS_SEQ_END   = 10'd6;
   localparam logic [OFS_BITS-1:0] POS_SRC_ID    = 10'd11;
   localparam logic [OFS_BITS-1:0] MIN_FRAME     = 10'd12;
   localparam logic [OFS_BITS-1:0] CONF_ID_BYTES = 10'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QCNT_BITS   = 2;

   typedef enum logic [3:0] {
      ST_OK         = 4'd0,
      ST_SHORT      = 4'd1,
      ST_MAGIC      = 4'd2,
      ST_KIND       = 4'd3,
      ST_SRC_LEN    = 4'd4,
      ST_SHORT_SRC  = 4'd5,
      ST_NO_DST     = 4'd6,
      ST_DST_LEN    = 4'd7,
      ST_SHORT_BODY = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      CLS_SRC     = 2'd0,
      CLS_DST     = 2'd1,
      CLS_PAYLOAD = 2'd2
   } byte_class_type;

   typedef struct packed {
      logic [7:0]           magic_value;
      logic [7:0]           max_id_len;
      logic [KIND_BITS-1:0] max_kind;
      logic [7:0]           conf_flag_mask;
      logic [7:0]           end_flag_mask;
      logic [7:0]           ack_flag_mask;
   } cfg_type;

   typedef struct packed {
      status_type           status;
      logic [KIND_BITS-1:0] media_kind;
      logic                 end_flag;
      logic                 ack_flag;
      logic                 conf_flag;
      logic [31:0]          sequence_res;
      logic [31:0]          time_ms;
      logic [31:0]          conference_id;
      logic [7:0]           source_len;
   } summary_type;

   typedef struct packed {
      logic           has_tag;
      byte_class_type byte_class;
      logic [7:0]     data_byte;
      logic           last;
      summary_type    summary;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic           is_summary;
      byte_class_type byte_class;
      logic [7:0]     data_byte;
      summary_type    summary;
   } rsp_type;

endpackage

// ===== sv/mfhp_if.sv =====
// ----------------------------------------------------------------------------
// Media frame header parser channels
// Byte input channel and result channel with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface mfhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, output frame_byte, output last_byte, input ready);
   modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface mfhp_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_summary;
   logic [1:0]  byte_class;
   logic [7:0]  data_byte;
   logic [3:0]  status;
   logic [3:0]  media_kind;
   logic        end_flag;
   logic        ack_flag;
   logic        conf_flag;
   logic [31:0] sequence_res;
   logic [31:0] time_ms;
   logic [31:0] conference_id;
   logic [7:0]  source_len;

   modport source (
      output valid, output is_summary, output byte_class, output data_byte,
      output status, output media_kind, output end_flag, output ack_flag,
      output conf_flag, output sequence_res, output time_ms,
      output conference_id, output source_len, input ready
   );
   modport sink (
      input valid, input is_summary, input byte_class, input data_byte,
      input status, input media_kind, input end_flag, input ack_flag,
      input conf_flag, input sequence_res, input time_ms,
      input conference_id, input source_len, output ready
   );
endinterface

// ===== sv/mfhp_front.sv =====
// ----------------------------------------------------------------------------
// Media frame header parser front end
// Tracks the byte position, collects header fields and classifies each item.
// ----------------------------------------------------------------------------
module mfhp_front #(
   parameter int POSITION_BITS = mfhp_pkg::POSITION_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  mfhp_pkg::cfg_type   cfg,
   input  logic                accept,
   input  logic [7:0]          frame_byte,
   input  logic                last_byte,
   output logic                push,
   output mfhp_pkg::entry_type push_entry
);

`include "media_frame_header_parser_top_defines.svh"

   localparam int CW = POSITION_BITS + 1;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  kind_ff, kind_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] time_ff, time_in;
   logic [7:0]  src_ff, src_in;
   logic [7:0]  dst_ff, dst_in;
   logic [31:0] conf_acc_ff, conf_acc_in;

   logic                           conf_old, conf_now, has_tag;
   mfhp_pkg::byte_class_type       cls;
   logic [mfhp_pkg::OFS_BITS-1:0]  src_end, dst_end, conf_end;
   logic [mfhp_pkg::OFS_BITS-1:0]  thr_src, thr_body;
   logic [1:0]                     hdr_lane, conf_lane;
   logic [CW-1:0]                  count;
   mfhp_pkg::status_type           status;

   assign conf_old  = |(kind_ff & cfg.conf_flag_mask);
   assign src_end   = mfhp_pkg::POS_SRC_ID + {2'b00, src_ff};
   assign dst_end   = mfhp_pkg::MIN_FRAME + {2'b00, src_ff} + {2'b00, dst_ff};
   assign conf_end  = dst_end + mfhp_pkg::CONF_ID_BYTES;
   // Sequence bytes start at position 2 and time bytes at 6, both four-aligned
   // after an offset of two, so the low position bits pick the byte lane.
   assign hdr_lane  = pos_ff[1:0] - 2'd2;
   assign conf_lane = pos_ff[1:0] - dst_end[1:0];

   always_comb begin
      first_in    = first_ff;
      kind_in     = kind_ff;
      seq_in      = seq_ff;
      time_in     = time_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      conf_acc_in = conf_acc_ff;
      conf_now    = conf_old;
      has_tag     = 1'b0;
      cls         = mfhp_pkg::CLS_PAYLOAD;
      if (pos_ff == '0) begin
         first_in = frame_byte;
      end else if (pos_ff == POSITION_BITS'(mfhp_pkg::POS_KIND)) begin
         kind_in  = frame_byte;
         conf_now = |(frame_byte & cfg.conf_flag_mask);
      end else if (pos_ff < POSITION_BITS'(mfhp_pkg::POS_SEQ_END)) begin
         seq_in[{hdr_lane, 3'b000} +: 8] = seq_ff[{hdr_lane, 3'b000} +: 8] | frame_byte;
      end else if (pos_ff < POSITION_BITS'(mfhp_pkg::POS_SRC_LEN)) begin
         time_in[{hdr_lane, 3'b000} +: 8] = time_ff[{hdr_lane, 3'b000} +: 8] | frame_byte;
      end else if (pos_ff == POSITION_BITS'(mfhp_pkg::POS_SRC_LEN)) begin
         src_in = frame_byte;
      end else if (pos_ff < POSITION_BITS'(src_end)) begin
         has_tag = 1'b1;
         cls     = mfhp_pkg::CLS_SRC;
      end else if (pos_ff == POSITION_BITS'(src_end)) begin
         dst_in = frame_byte;
      end else if (pos_ff < POSITION_BITS'(dst_end)) begin
         has_tag = 1'b1;
         cls     = mfhp_pkg::CLS_DST;
      end else if (conf_old && (pos_ff < POSITION_BITS'(conf_end))) begin
         conf_acc_in[{conf_lane, 3'b000} +: 8] =
            conf_acc_ff[{conf_lane, 3'b000} +: 8] | frame_byte;
      end else begin
         has_tag = 1'b1;
         cls     = mfhp_pkg::CLS_PAYLOAD;
      end
   end

   // Length checks see the frame as it stands after this item.
   assign count    = {1'b0, pos_ff} + CW'(1);
   assign thr_src  = mfhp_pkg::MIN_FRAME + {2'b00, src_in};
   assign thr_body = thr_src + {2'b00, dst_in}
                   + (conf_now ? mfhp_pkg::CONF_ID_BYTES : '0);

   always_comb begin
      if (count < CW'(mfhp_pkg::MIN_FRAME)) begin
         status = mfhp_pkg::ST_SHORT;
      end else if (first_in != cfg.magic_value) begin
         status = mfhp_pkg::ST_MAGIC;
      end else if (kind_in[mfhp_pkg::KIND_BITS-1:0] > cfg.max_kind) begin
         status = mfhp_pkg::ST_KIND;
      end else if ((src_in == '0) || (src_in > cfg.max_id_len)) begin
         status = mfhp_pkg::ST_SRC_LEN;
      end else if (count < CW'(thr_src)) begin
         status = mfhp_pkg::ST_SHORT_SRC;
      end else if ((dst_in == '0) && !conf_now) begin
         status = mfhp_pkg::ST_NO_DST;
      end else if (dst_in > cfg.max_id_len) begin
         status = mfhp_pkg::ST_DST_LEN;
      end else if (count < CW'(thr_body)) begin
         status = mfhp_pkg::ST_SHORT_BODY;
      end else begin
         status = mfhp_pkg::ST_OK;
      end
   end

   always_comb begin
      push_entry                       = '0;
      push_entry.has_tag               = has_tag;
      push_entry.byte_class            = cls;
      push_entry.data_byte             = frame_byte;
      push_entry.last                  = last_byte;
      push_entry.summary.status        = status;
      push_entry.summary.media_kind    = kind_in[mfhp_pkg::KIND_BITS-1:0];
      push_entry.summary.end_flag      = |(kind_in & cfg.end_flag_mask);
      push_entry.summary.ack_flag      = |(kind_in & cfg.ack_flag_mask);
      push_entry.summary.conf_flag     = conf_now;
      push_entry.summary.sequence_res  = seq_in;
      push_entry.summary.time_ms       = time_in;
      push_entry.summary.conference_id = conf_now ? conf_acc_in : '0;
      push_entry.summary.source_len    = src_in;
   end

   assign push   = accept && (has_tag || last_byte);
   assign pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POSITION_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         pos_ff      <= '0;
         first_ff    <= '0;
         kind_ff     <= '0;
         seq_ff      <= '0;
         time_ff     <= '0;
         src_ff      <= '0;
         dst_ff      <= '0;
         conf_acc_ff <= '0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         first_ff    <= first_in;
         kind_ff     <= kind_in;
         seq_ff      <= seq_in;
         time_ff     <= time_in;
         src_ff      <= src_in;
         dst_ff      <= dst_in;
         conf_acc_ff <= conf_acc_in;
      end
   end

   `MFHP_ASSERT_NEXT(a_frame_restarts, clock, reset, accept && last_byte, pos_ff == '0 && src_ff == '0, "position not cleared after the last item of a frame")

endmodule

// ===== sv/mfhp_queue.sv =====
// ----------------------------------------------------------------------------
// Media frame header parser queue
// Short FIFO of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
module mfhp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mfhp_pkg::entry_type push_entry,
   input  logic                pop,
   output mfhp_pkg::entry_type head,
   output mfhp_pkg::qstat_type qstat
);

`include "media_frame_header_parser_top_defines.svh"

   localparam logic [mfhp_pkg::QPTR_BITS-1:0] LAST_SLOT =
      mfhp_pkg::QPTR_BITS'(mfhp_pkg::QUEUE_DEPTH - 1);

   mfhp_pkg::entry_type ents_ff [mfhp_pkg::QUEUE_DEPTH];
   logic [mfhp_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [mfhp_pkg::QCNT_BITS-1:0] cnt_ff, cnt_in;

   assign qstat.full  = (cnt_ff == mfhp_pkg::QCNT_BITS'(mfhp_pkg::QUEUE_DEPTH));
   assign qstat.empty = (cnt_ff == '0);
   assign head        = ents_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 :
                     wr_ptr_ff + mfhp_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 :
                     rd_ptr_ff + mfhp_pkg::QPTR_BITS'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + mfhp_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - mfhp_pkg::QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ents_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `MFHP_ASSERT_IMPL(a_no_overflow, clock, reset, push, !qstat.full || pop, "item pushed into a full queue")
   `MFHP_ASSERT_IMPL(a_no_underflow, clock, reset, pop, !qstat.empty, "item popped from an empty queue")

endmodule

// ===== sv/mfhp_back.sv =====
// ----------------------------------------------------------------------------
// Media frame header parser back end
// Turns queued items into tagged-byte and summary results in an output register.
// ----------------------------------------------------------------------------
module mfhp_back (
   input  logic                clock,
   input  logic                reset,
   input  mfhp_pkg::entry_type head,
   input  mfhp_pkg::qstat_type qstat,
   output logic                pop,
   mfhp_rsp_if.source          rsp
);

`include "media_frame_header_parser_top_defines.svh"

   mfhp_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   // Set while the head item's tagged byte is out and its summary is still owed.
   logic              sub_ff, sub_in;
   logic              load;

   assign load = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      sub_in       = sub_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = !qstat.empty;
         if (!qstat.empty) begin
            rsp_in = '0;
            if (head.has_tag && !sub_ff) begin
               rsp_in.byte_class = head.byte_class;
               rsp_in.data_byte  = head.data_byte;
               if (head.last) begin
                  sub_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end else begin
               rsp_in.is_summary = 1'b1;
               rsp_in.summary    = head.summary;
               sub_in            = 1'b0;
               pop               = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sub_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sub_ff       <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.is_summary    = rsp_ff.is_summary;
   assign rsp.byte_class    = rsp_ff.byte_class;
   assign rsp.data_byte     = rsp_ff.data_byte;
   assign rsp.status        = rsp_ff.summary.status;
   assign rsp.media_kind    = rsp_ff.summary.media_kind;
   assign rsp.end_flag      = rsp_ff.summary.end_flag;
   assign rsp.ack_flag      = rsp_ff.summary.ack_flag;
   assign rsp.conf_flag     = rsp_ff.summary.conf_flag;
   assign rsp.sequence_res  = rsp_ff.summary.sequence_res;
   assign rsp.time_ms       = rsp_ff.summary.time_ms;
   assign rsp.conference_id = rsp_ff.summary.conference_id;
   assign rsp.source_len    = rsp_ff.summary.source_len;

   `MFHP_ASSERT_IMPL(a_owed_summary_head, clock, reset, sub_ff, !qstat.empty && head.last && head.has_tag, "summary owed but head item is not a tagged last item")
   `MFHP_ASSERT_IMPL(a_summary_clean, clock, reset, rsp_valid_ff && rsp_ff.is_summary, rsp_ff.byte_class == mfhp_pkg::CLS_SRC && rsp_ff.data_byte == '0, "summary result carries tagged-byte fields")

endmodule

// ===== sv/media_frame_header_parser_top.sv =====
// ----------------------------------------------------------------------------
// Media frame header parser
// Byte-stream frame header decoder with tagged id/payload bytes and a summary.
// ----------------------------------------------------------------------------
// The parser takes one frame byte per item on req_bus, with last_byte marking
// the end of a frame, and accepts a new item in every cycle while its two-entry
// queue has room. Source id, destination id and payload bytes come out on
// rsp_bus as tagged items as they arrive; header, length and conference id
// bytes produce nothing. The last byte of a frame adds a summary item with the
// decoded header fields and a status code. An accepted byte goes through the
// queue and then the output register. The single output register gives one
// item per cycle while the result side is ready; a last byte that is also
// tagged produces two results, which the queue absorbs. The front end keeps
// the position count (saturating at its all-ones value) and the header fields
// and resolves the status checks in the cycle the last byte arrives; the back
// end only sequences results. Configuration registers are written through
// csr_we/csr_index/csr_wdata and should only be changed while no item is in
// flight; writes to an index beyond the register list are ignored.
// ----------------------------------------------------------------------------
module media_frame_header_parser_top #(
   parameter int POSITION_BITS = mfhp_pkg::POSITION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   mfhp_req_if.sink                            req_bus,
   mfhp_rsp_if.source                          rsp_bus,
   input  logic                                csr_we,
   input  logic [mfhp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mfhp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   mfhp_pkg::cfg_type   cfg_ff, cfg_in;
   mfhp_pkg::entry_type push_entry, head;
   mfhp_pkg::qstat_type qstat;
   logic                accept, push, pop;

   // Register file: each write lands in one field; unknown indexes do nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            mfhp_pkg::CSR_MAGIC:      cfg_in.magic_value    = csr_wdata;
            mfhp_pkg::CSR_MAX_ID_LEN: cfg_in.max_id_len     = csr_wdata;
            mfhp_pkg::CSR_MAX_KIND:   cfg_in.max_kind       =
               csr_wdata[mfhp_pkg::KIND_BITS-1:0];
            mfhp_pkg::CSR_CONF_MASK:  cfg_in.conf_flag_mask = csr_wdata;
            mfhp_pkg::CSR_END_MASK:   cfg_in.end_flag_mask  = csr_wdata;
            mfhp_pkg::CSR_ACK_MASK:   cfg_in.ack_flag_mask  = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_value    <= mfhp_pkg::RST_MAGIC;
         cfg_ff.max_id_len     <= mfhp_pkg::RST_MAX_ID_LEN;
         cfg_ff.max_kind       <= mfhp_pkg::RST_MAX_KIND;
         cfg_ff.conf_flag_mask <= mfhp_pkg::RST_CONF_MASK;
         cfg_ff.end_flag_mask  <= mfhp_pkg::RST_END_MASK;
         cfg_ff.ack_flag_mask  <= mfhp_pkg::RST_ACK_MASK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end stalls only when the queue is full, never on the output.
   assign req_bus.ready = !qstat.full;
   assign accept        = req_bus.valid && !qstat.full;

   mfhp_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .frame_byte (req_bus.frame_byte),
      .last_byte  (req_bus.last_byte),
      .push       (push),
      .push_entry (push_entry)
   );

   mfhp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   mfhp_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .qstat (qstat),
      .pop   (pop),
      .rsp   (rsp_bus)
   );

endmodule

// ===== bench/media_frame_header_parser_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Media frame header parser testbench
// Sends whole frames, one byte per item, and checks every tagged byte and
// every end-of-frame summary against a predictor kept inside the bench,
// across several register settings.
// ----------------------------------------------------------------------------
module media_frame_header_parser_top_test;

   // The bench runs the parser at its default position width. Frames stay
   // far below the saturation point, so the count never sticks here.
   localparam int POS_BITS     = mfhp_pkg::POSITION_BITS_DEF;
   localparam int HEADER_BYTES = 12;      // shortest frame with all fixed fields
   localparam int CONF_BYTES   = 4;
   localparam logic [7:0] MEDIA_KIND_MASK = 8'h0F;

   // Indexes past the register list; writes there must change nothing.
   localparam logic [mfhp_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [mfhp_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   localparam int RANDOM_BYTES   = 400;
   localparam int SETTLE_CYCLES  = 6;     // margin for the queue and output register to empty
   localparam int DRAIN_LIMIT    = 20000;
   localparam int LONG_HOLD      = 240;
   localparam int RUN_LIMIT_NS   = 10_000_000;

   // One frame to send: header contents, declared id lengths and the number
   // of bytes actually sent. When has_status is set, the summary status is
   // the typed value rather than the predicted one.
   typedef struct {
      logic [7:0]           magic;
      logic [7:0]           kind;
      logic [31:0]          seq;
      logic [31:0]          stamp;
      logic [7:0]           slen;
      logic [7:0]           dlen;
      int                   total;
      bit                   has_status;
      mfhp_pkg::status_type status;
   } frame_plan;

   logic clock;
   logic reset;
   logic csr_we;
   logic [mfhp_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [mfhp_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   mfhp_req_if req_bus ();
   mfhp_rsp_if rsp_bus ();

   media_frame_header_parser_top #(
      .POSITION_BITS(POS_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Predictor state: a private copy of the registers and of the per-frame
   // decode state. It advances once per accepted byte.
   // -------------------------------------------------------------------------
   mfhp_pkg::cfg_type   cfg;
   logic [POS_BITS-1:0] pos_count;
   logic [7:0]          magic_r;
   logic [7:0]          kind_r;
   logic [31:0]         seq_r;
   logic [31:0]         time_r;
   logic [7:0]          src_len_r;
   logic [7:0]          dst_len_r;
   logic [31:0]         conf_r;

   // Results still owed by the parser, oldest first.
   mfhp_pkg::rsp_type results_due[$];

   int  fault_count    = 0;
   int  frames_sent    = 0;
   int  bytes_sent     = 0;
   int  results_seen   = 0;
   int  input_stalls   = 0;
   int  phases_run     = 0;
   logic [8:0] status_seen = '0;

   // Idling controls shared between the feeding and draining processes.
   bit feed_gaps  = 1'b1;
   bit drain_gaps = 1'b1;
   bit long_hold  = 1'b0;

   // Directed frames, all under the reset settings (magic 0, ids up to 15
   // bytes, kinds up to 3, conference bit 0x10). The status is typed in
   // wherever it follows directly from the header; one frame is left to
   // the predictor.
   frame_plan directed_frames [15] = '{
      // A lone byte, then a frame cut one byte short of the fixed header.
      '{8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000, 8'd1,  8'd1,  1,  1'b1,
        mfhp_pkg::ST_SHORT},
      '{8'h00, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1,  8'd1,  11, 1'b1,
        mfhp_pkg::ST_SHORT},
      // Wrong magic, then a media kind above the limit.
      '{8'hFF, 8'h00, 32'h1234_5678, 32'h9ABC_DEF0, 8'd1,  8'd1,  14, 1'b1,
        mfhp_pkg::ST_MAGIC},
      '{8'h00, 8'h04, 32'h0000_0001, 32'h8000_0000, 8'd1,  8'd1,  14, 1'b1,
        mfhp_pkg::ST_KIND},
      // Source length of zero and one past the limit.
      '{8'h00, 8'hF3, 32'hFFFF_FFFF, 32'h0000_0000, 8'd0,  8'd1,  20, 1'b1,
        mfhp_pkg::ST_SRC_LEN},
      '{8'h00, 8'h01, 32'h0000_0000, 32'hFFFF_FFFF, 8'd16, 8'd1,  40, 1'b1,
        mfhp_pkg::ST_SRC_LEN},
      // Frame ends inside the source id.
      '{8'h00, 8'h02, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'd5,  8'd1,  14, 1'b1,
        mfhp_pkg::ST_SHORT_SRC},
      // No destination and no conference id.
      '{8'h00, 8'h00, 32'h0000_00FF, 32'hFF00_0000, 8'd2,  8'd0,  14, 1'b1,
        mfhp_pkg::ST_NO_DST},
      // No destination, but a conference id makes the frame good.
      '{8'h00, 8'h10, 32'hDEAD_BEEF, 32'h0BAD_F00D, 8'd2,  8'd0,  18, 1'b1,
        mfhp_pkg::ST_OK},
      // Destination length past the limit.
      '{8'h00, 8'h03, 32'h0000_0000, 32'h0000_0000, 8'd1,  8'd16, 40, 1'b1,
        mfhp_pkg::ST_DST_LEN},
      // Frame ends inside the conference id.
      '{8'h00, 8'h13, 32'h0102_0304, 32'h0506_0708, 8'd3,  8'd3,  20, 1'b1,
        mfhp_pkg::ST_SHORT_BODY},
      // Longest ids, every flag, payload after the conference id.
      '{8'h00, 8'h73, 32'hFFFF_FFFF, 32'h0000_0000, 8'd15, 8'd15, 50, 1'b1,
        mfhp_pkg::ST_OK},
      // Shortest good frame: last byte is the destination id byte.
      '{8'h00, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 8'd1,  8'd1,  14, 1'b1,
        mfhp_pkg::ST_OK},
      // Shortest frame that passes the length check but not the source id.
      '{8'h00, 8'h01, 32'h0000_0000, 32'h0000_0000, 8'd1,  8'd1,  12, 1'b1,
        mfhp_pkg::ST_SHORT_SRC},
      // Ordinary frame with payload ending on a tagged byte.
      '{8'h00, 8'h62, 32'h7654_3210, 32'h0000_1000, 8'd4,  8'd2,  30, 1'b0,
        mfhp_pkg::ST_OK}
   };

   // Register settings for the random phases, extremes first.
   mfhp_pkg::cfg_type phase_settings [4] = '{
      '{8'hFF, 8'd1,   4'd0,  8'h80, 8'h01, 8'h02},
      '{8'h5A, 8'd255, 4'd15, 8'hFF, 8'hFF, 8'hFF},
      '{8'h00, 8'd8,   4'd7,  8'h00, 8'h00, 8'h00},
      '{8'h00, 8'd15,  4'd3,  8'h10, 8'h20, 8'h40}
   };

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------
   function automatic void clear_frame_state();
      pos_count = '0;
      magic_r   = '0;
      kind_r    = '0;
      seq_r     = '0;
      time_r    = '0;
      src_len_r = '0;
      dst_len_r = '0;
      conf_r    = '0;
   endfunction

   // Checks run in a fixed order and the first that fails sets the status.
   function automatic mfhp_pkg::status_type frame_verdict(int count, bit conf_on);
      int s;
      int d;
      s = int'(src_len_r);
      d = int'(dst_len_r);
      if (count < HEADER_BYTES) return mfhp_pkg::ST_SHORT;
      if (magic_r != cfg.magic_value) return mfhp_pkg::ST_MAGIC;
      if ((kind_r & MEDIA_KIND_MASK) > cfg.max_kind) return mfhp_pkg::ST_KIND;
      if (s == 0 || s > cfg.max_id_len) return mfhp_pkg::ST_SRC_LEN;
      if (count < HEADER_BYTES + s) return mfhp_pkg::ST_SHORT_SRC;
      if (d == 0 && !conf_on) return mfhp_pkg::ST_NO_DST;
      if (d > cfg.max_id_len) return mfhp_pkg::ST_DST_LEN;
      if (count < HEADER_BYTES + s + d + (conf_on ? CONF_BYTES : 0)) begin
         return mfhp_pkg::ST_SHORT_BODY;
      end
      return mfhp_pkg::ST_OK;
   endfunction

   // Advances the frame decode by one accepted byte and queues the results
   // it causes: a tagged byte for id and payload positions, then a summary
   // when the byte ends the frame.
   function automatic void decode_frame_byte(logic [7:0] value, logic ends_frame);
      int                       p;
      int                       s;
      int                       dend;
      bit                       conf_on;
      bit                       tag_hit;
      mfhp_pkg::byte_class_type cls;
      mfhp_pkg::rsp_type        r;
      p       = int'(pos_count);
      s       = int'(src_len_r);
      conf_on = (kind_r & cfg.conf_flag_mask) != 0;
      tag_hit = 1'b0;
      cls     = mfhp_pkg::CLS_SRC;
      if (p == 0) begin
         magic_r = value;
      end else if (p == 1) begin
         kind_r  = value;
         conf_on = (value & cfg.conf_flag_mask) != 0;
      end else if (p < 6) begin
         seq_r = seq_r | (32'(value) << (8 * (p - 2)));
      end else if (p < 10) begin
         time_r = time_r | (32'(value) << (8 * (p - 6)));
      end else if (p == 10) begin
         src_len_r = value;
      end else if (p < 11 + s) begin
         tag_hit = 1'b1;
         cls     = mfhp_pkg::CLS_SRC;
      end else if (p == 11 + s) begin
         dst_len_r = value;
      end else begin
         // Tagging uses only the lengths seen so far, good frame or not.
         dend = HEADER_BYTES + s + int'(dst_len_r);
         if (p < dend) begin
            tag_hit = 1'b1;
            cls     = mfhp_pkg::CLS_DST;
         end else if (conf_on && p < dend + CONF_BYTES) begin
            conf_r = conf_r | (32'(value) << (8 * (p - dend)));
         end else begin
            tag_hit = 1'b1;
            cls     = mfhp_pkg::CLS_PAYLOAD;
         end
      end

      if (tag_hit) begin
         r            = '0;
         r.byte_class = cls;
         r.data_byte  = value;
         results_due  = {results_due, r};
      end

      // The position count sticks at all ones on very long frames.
      if (pos_count != '1) pos_count = pos_count + POS_BITS'(1);

      if (ends_frame) begin
         r                       = '0;
         r.is_summary            = 1'b1;
         r.summary.status        = frame_verdict(p + 1, conf_on);
         r.summary.media_kind    = kind_r[3:0];
         r.summary.end_flag      = (kind_r & cfg.end_flag_mask) != 0;
         r.summary.ack_flag      = (kind_r & cfg.ack_flag_mask) != 0;
         r.summary.conf_flag     = conf_on;
         r.summary.sequence_res  = seq_r;
         r.summary.time_ms       = time_r;
         r.summary.conference_id = conf_on ? conf_r : 32'h0;
         r.summary.source_len    = src_len_r;
         results_due             = {results_due, r};
         clear_frame_state();
      end
   endfunction

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------
   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fault_count++;
      end
   endfunction

   // Called at the edge where a result is accepted, so the fields read here
   // are the values that were held across that edge.
   function automatic void check_result();
      mfhp_pkg::rsp_type want;
      if (results_due.size() == 0) begin
         $error("result item arrived with nothing due (is_summary %0b, data 0x%0h)",
                rsp_bus.is_summary, rsp_bus.data_byte);
         fault_count++;
         return;
      end
      want = results_due.pop_front();
      results_seen++;
      compare_field("is_summary",    want.is_summary,            rsp_bus.is_summary);
      compare_field("byte_class",    want.byte_class,            rsp_bus.byte_class);
      compare_field("data_byte",     want.data_byte,             rsp_bus.data_byte);
      compare_field("status",        want.summary.status,        rsp_bus.status);
      compare_field("media_kind",    want.summary.media_kind,    rsp_bus.media_kind);
      compare_field("end_flag",      want.summary.end_flag,      rsp_bus.end_flag);
      compare_field("ack_flag",      want.summary.ack_flag,      rsp_bus.ack_flag);
      compare_field("conf_flag",     want.summary.conf_flag,     rsp_bus.conf_flag);
      compare_field("sequence_res",  want.summary.sequence_res,  rsp_bus.sequence_res);
      compare_field("time_ms",       want.summary.time_ms,       rsp_bus.time_ms);
      compare_field("conference_id", want.summary.conference_id, rsp_bus.conference_id);
      compare_field("source_len",    want.summary.source_len,    rsp_bus.source_len);
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Offers one byte and holds it until the parser takes it. Valid is only
   // dropped when a gap follows, so back-to-back items keep it high.
   task automatic send_byte(input logic [7:0] value, input logic ends_frame);
      int gap;
      gap = feed_gaps ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.frame_byte <= value;
      req_bus.last_byte  <= ends_frame;
      @(posedge clock);
      while (!req_bus.ready) begin
         input_stalls++;
         @(posedge clock);
      end
      decode_frame_byte(value, ends_frame);
      bytes_sent++;
   endtask

   // Lays the frame out byte by byte from the plan, then cuts it or pads it
   // with payload to the planned total. The conference id is present when
   // the kind byte matches the current mask, as the parser will see it.
   task automatic send_frame(input frame_plan plan);
      logic [7:0]  frame_q[$];
      logic [31:0] conf_id;
      bit          conf_on;
      int          k;
      conf_on = (plan.kind & cfg.conf_flag_mask) != 0;
      conf_id = $urandom;
      frame_q = {frame_q, plan.magic};
      frame_q = {frame_q, plan.kind};
      for (k = 0; k < 4; k++) frame_q = {frame_q, plan.seq[8*k +: 8]};
      for (k = 0; k < 4; k++) frame_q = {frame_q, plan.stamp[8*k +: 8]};
      frame_q = {frame_q, plan.slen};
      for (k = 0; k < plan.slen; k++) frame_q = {frame_q, 8'($urandom)};
      frame_q = {frame_q, plan.dlen};
      for (k = 0; k < plan.dlen; k++) frame_q = {frame_q, 8'($urandom)};
      if (conf_on) begin
         for (k = 0; k < CONF_BYTES; k++) frame_q = {frame_q, conf_id[8*k +: 8]};
      end
      while (frame_q.size() < plan.total) frame_q = {frame_q, 8'($urandom)};
      while (frame_q.size() > plan.total) void'(frame_q.pop_back());

      for (k = 0; k < frame_q.size(); k++) begin
         send_byte(frame_q[k], k == frame_q.size() - 1);
      end
      // The summary is the newest expectation; a typed status replaces the
      // predicted one so the directed frames are checked against fixed codes.
      if (plan.has_status) begin
         results_due[results_due.size() - 1].summary.status = plan.status;
      end
      status_seen[results_due[results_due.size() - 1].summary.status] = 1'b1;
      frames_sent++;
   endtask

   // Mostly well-formed frames with random content, so the decode gets past
   // the header; a share of them is cut short, carries bad fields, or is
   // plain noise.
   function automatic frame_plan random_plan();
      frame_plan plan;
      int        id_cap;
      int        layout;
      int        pick;
      bit        conf_on;
      plan.magic = ($urandom_range(0, 9) != 0) ? cfg.magic_value : 8'($urandom);
      plan.kind  = 8'($urandom);
      if ($urandom_range(0, 3) != 0) plan.kind[3:0] = 4'($urandom_range(0, cfg.max_kind));
      plan.seq   = $urandom;
      plan.stamp = $urandom;
      // Long ids make long frames, so the full limit is used only now and then.
      id_cap = (cfg.max_id_len > 4 && $urandom_range(0, 15) != 0) ? 4 : cfg.max_id_len;
      plan.slen = ($urandom_range(0, 11) == 0) ? 8'($urandom) : 8'($urandom_range(1, id_cap));
      plan.dlen = ($urandom_range(0, 11) == 0) ? 8'($urandom) : 8'($urandom_range(0, id_cap));
      conf_on = (plan.kind & cfg.conf_flag_mask) != 0;
      layout  = HEADER_BYTES + plan.slen + plan.dlen + (conf_on ? CONF_BYTES : 0);
      pick    = $urandom_range(0, 9);
      if (pick < 7) begin
         plan.total = layout + $urandom_range(0, 6);
      end else if (pick < 9) begin
         plan.total = $urandom_range(1, layout);
      end else begin
         plan.magic = 8'($urandom);
         plan.total = $urandom_range(1, 24);
      end
      plan.has_status = 1'b0;
      plan.status     = mfhp_pkg::ST_OK;
      return plan;
   endfunction

   // Writes one register and mirrors the write into the predictor. The
   // enable is dropped for a cycle so back-to-back writes never raise and
   // lower it in the same step.
   task automatic write_reg(input logic [mfhp_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (index)
         mfhp_pkg::CSR_MAGIC:      cfg.magic_value    = value;
         mfhp_pkg::CSR_MAX_ID_LEN: cfg.max_id_len     = value;
         mfhp_pkg::CSR_MAX_KIND:   cfg.max_kind       = value[3:0];
         mfhp_pkg::CSR_CONF_MASK:  cfg.conf_flag_mask = value;
         mfhp_pkg::CSR_END_MASK:   cfg.end_flag_mask  = value;
         mfhp_pkg::CSR_ACK_MASK:   cfg.ack_flag_mask  = value;
         default: ;
      endcase
   endtask

   // Registers may only change with nothing in flight: every expected
   // result has come back and the pipeline has had time to empty.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input mfhp_pkg::cfg_type s);
      wait_idle();
      // Stray indexes first; the predictor ignores them, so must the parser.
      write_reg(CSR_SPARE_LO, 8'($urandom));
      write_reg(CSR_SPARE_HI, 8'($urandom));
      write_reg(mfhp_pkg::CSR_MAGIC,      s.magic_value);
      write_reg(mfhp_pkg::CSR_MAX_ID_LEN, s.max_id_len);
      write_reg(mfhp_pkg::CSR_MAX_KIND,   8'(s.max_kind));
      write_reg(mfhp_pkg::CSR_CONF_MASK,  s.conf_flag_mask);
      write_reg(mfhp_pkg::CSR_END_MASK,   s.end_flag_mask);
      write_reg(mfhp_pkg::CSR_ACK_MASK,   s.ack_flag_mask);
      phases_run++;
   endtask

   // -------------------------------------------------------------------------
   // Clock
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Result side: draws a stall before every item, and once per run sits on
   // a long hold-off when asked, so the parser's queue fills and its input
   // backs up.
   // -------------------------------------------------------------------------
   initial begin : drain_results
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            stall     = LONG_HOLD;
         end else begin
            stall = drain_gaps ? $urandom_range(0, 19) : 0;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         check_result();
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence: reset, directed frames, random phases under several
   // register settings, the back-pressure frame, and the final drain.
   // -------------------------------------------------------------------------
   initial begin : run_frames
      frame_plan plan;
      int        phase;
      int        target;
      int        waited;

      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.frame_byte <= '0;
      req_bus.last_byte  <= 1'b0;
      cfg = '{mfhp_pkg::RST_MAGIC, mfhp_pkg::RST_MAX_ID_LEN, mfhp_pkg::RST_MAX_KIND,
              mfhp_pkg::RST_CONF_MASK, mfhp_pkg::RST_END_MASK, mfhp_pkg::RST_ACK_MASK};
      clear_frame_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames under the reset settings, with idling on both sides
      // for the first half and none for the rest.
      foreach (directed_frames[i]) begin
         feed_gaps  = (i < 8);
         drain_gaps = (i < 8);
         send_frame(directed_frames[i]);
      end

      // Random frames, a share of the byte budget per settings phase. The
      // last phase uses random register values.
      for (phase = 0; phase <= 4; phase++) begin
         if (phase < 4) begin
            apply_settings(phase_settings[phase]);
         end else begin
            apply_settings('{8'($urandom), 8'($urandom_range(1, 255)), 4'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom)});
         end
         target = bytes_sent + RANDOM_BYTES / 5;
         while (bytes_sent < target) begin
            // Per frame, each side either idles at random or runs flat out.
            feed_gaps  = ($urandom_range(0, 3) != 0);
            drain_gaps = ($urandom_range(0, 3) != 0);
            send_frame(random_plan());
         end
      end

      // Back to the reset settings for the long frame.
      apply_settings(phase_settings[3]);

      // Back-pressure: the result side holds off for a long stretch right
      // after the first id byte comes out, while bytes keep being offered.
      feed_gaps  = 1'b0;
      drain_gaps = 1'b0;
      long_hold  = 1'b1;
      plan = '{8'h00, 8'h21, 32'h0, 32'h0, 8'd1, 8'd1, 80, 1'b0, mfhp_pkg::ST_OK};
      plan.seq   = $urandom;
      plan.stamp = $urandom;
      send_frame(plan);

      // One more short random stretch so the parser is seen to recover.
      feed_gaps  = 1'b1;
      drain_gaps = 1'b1;
      repeat (6) send_frame(random_plan());

      req_bus.valid <= 1'b0;
      waited = 0;
      while (results_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (results_due.size() != 0) begin
         $error("%0d expected result items never arrived", results_due.size());
         fault_count++;
      end

      $display("Run covered %0d frames, %0d bytes and %0d checked results over %0d settings.",
               frames_sent, bytes_sent, results_seen, phases_run);
      $display("Status codes reached (bit per code): %b; input held off for %0d cycles.",
               status_seen, input_stalls);
      if (fault_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // A hung handshake ends the run here instead of hanging the simulator.
   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("FAILURE");
      $finish;
   end

endmodule
